@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ sv/mcp_pkg.sv @@
// Shared types and constants of the motor command parser.
`timescale 1ns / 1ps
package mcp_pkg;
    localparam logic [15:0] ABS_MAX   = 16'd65025;
    localparam logic [15:0] MIN_RESET = 16'd30000;
    localparam logic [16:0] NUM_SAT   = 17'd131071;
    localparam int          QDEPTH_DEF = 4;

    // Job opcodes passed from the parser to the reply generator.
    typedef enum logic [2:0] {
        OP_UNSUP = 3'd0,
        OP_DEC   = 3'd1,
        OP_BRAKE = 3'd2,
        OP_ZERO  = 3'd3,
        OP_OK    = 3'd4,
        OP_DRIVE = 3'd5
    } t_op;

    // One finished command: what to emit and the operand for it.
    typedef struct packed {
        t_op         op;
        logic [15:0] value;
        logic        mv_nz;
        logic        mv_neg;
        logic        rt_nz;
        logic        rt_neg;
    } t_job;

    localparam int JOB_W = $bits(t_job);
endpackage

@@ sv/mcp_front.sv @@
// Front end: filters bytes, parses commands and issues finished jobs.
`timescale 1ns / 1ps
module mcp_front import mcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    output logic       o_job_valid,
    output t_job       o_job,
    input  logic       i_job_full
);
    logic        r_halted;
    logic [1:0]  r_cnt;
    logic [7:0]  r_letter;
    logic [16:0] r_num;
    logic        r_num_ok, r_split;
    logic [1:0]  r_mph, r_rph;
    logic        r_mnz, r_mneg, r_rnz, r_rneg;
    logic [2:0]  r_exit;
    logic [15:0] r_max, r_min, r_cur;

    logic [1:0]  n_ph, n_cur_ph;
    logic        n_nz, n_neg, sel_nz, sel_neg;
    logic        take, is_digit, is_letter, term, in_rng, issue;
    logic [20:0] num_x10;
    logic [7:0]  exit_chr;

    assign o_ready = !i_job_full;
    assign take    = i_valid && o_ready;
    assign is_digit  = i_byte >= 8'h30 && i_byte <= 8'h39;
    assign is_letter = (i_byte >= 8'h41 && i_byte <= 8'h5A) ||
                       (i_byte >= 8'h61 && i_byte <= 8'h7A);
    assign term    = i_byte == 8'h23;
    assign in_rng  = i_byte >= 8'd35 && i_byte <= 8'd122;
    assign issue   = take && !r_halted && in_rng && r_cnt != 2'd0 && term &&
                     r_exit != 3'd4;
    assign num_x10 = {r_num, 3'b000} + {3'b000, r_num, 1'b0} + {13'd0, i_byte - 8'h30};

    always_comb begin
        case (r_exit)
            3'd0: exit_chr = 8'h65;
            3'd1: exit_chr = 8'h78;
            3'd2: exit_chr = 8'h69;
            3'd3: exit_chr = 8'h74;
            default: exit_chr = 8'h00;
        endcase
    end

    // Sign and digit tracking of the part that is active now.
    always_comb begin
        n_cur_ph = r_split ? r_rph : r_mph;
        sel_nz   = r_split ? r_rnz : r_mnz;
        sel_neg  = r_split ? r_rneg : r_mneg;
        n_ph = n_cur_ph;
        n_nz = sel_nz;
        n_neg = sel_neg;
        if (n_cur_ph == 2'd0) begin
            if (i_byte == 8'h2D) begin
                n_neg = 1'b1;
                n_ph = 2'd1;
            end else if (i_byte == 8'h2B) begin
                n_ph = 2'd1;
            end else if (is_digit) begin
                n_nz = sel_nz | (i_byte != 8'h30);
                n_ph = 2'd2;
            end else begin
                n_ph = 2'd3;
            end
        end else if (n_cur_ph != 2'd3) begin
            if (is_digit) begin
                n_nz = sel_nz | (i_byte != 8'h30);
                n_ph = 2'd2;
            end else begin
                n_ph = 2'd3;
            end
        end
    end

    // Job valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_job_valid <= 1'b0;
        end else begin
            o_job_valid <= issue;
        end
    end

    // Parser state and job issue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted <= 1'b0;
            r_max <= ABS_MAX;
            r_min <= MIN_RESET;
            r_cur <= ABS_MAX;
            r_cnt <= 2'd0; r_letter <= 8'd0; r_num <= 17'd0; r_num_ok <= 1'b1;
            r_split <= 1'b0; r_mph <= 2'd0; r_rph <= 2'd0; r_mnz <= 1'b0;
            r_mneg <= 1'b0; r_rnz <= 1'b0; r_rneg <= 1'b0; r_exit <= 3'd0;
        end else if (take && !r_halted && in_rng) begin
            if (r_cnt == 2'd0) begin
                if (is_letter) begin
                    r_letter <= i_byte;
                    r_cnt <= 2'd1;
                    r_exit <= (i_byte == 8'h65) ? 3'd1 : 3'd7;
                end
            end else if (term) begin
                r_cnt <= 2'd0; r_letter <= 8'd0; r_num <= 17'd0; r_num_ok <= 1'b1;
                r_split <= 1'b0; r_mph <= 2'd0; r_rph <= 2'd0; r_mnz <= 1'b0;
                r_mneg <= 1'b0; r_rnz <= 1'b0; r_rneg <= 1'b0; r_exit <= 3'd0;
                if (r_exit == 3'd4) begin
                    r_halted <= 1'b1;
                end else begin
                    o_job.mv_nz <= r_mnz; o_job.mv_neg <= r_mneg;
                    o_job.rt_nz <= r_rnz; o_job.rt_neg <= r_rneg;
                    o_job.value <= (r_cnt == 2'd1 && r_letter == 8'h56) ? r_max :
                                   (r_cnt == 2'd1 && r_letter == 8'h76) ? r_min : r_cur;
                    if (r_cnt == 2'd1) begin
                        case (r_letter)
                            8'h49: o_job.op <= OP_UNSUP;
                            8'h56, 8'h76, 8'h63: o_job.op <= OP_DEC;
                            8'h62: o_job.op <= OP_BRAKE;
                            default: o_job.op <= OP_ZERO;
                        endcase
                    end else begin
                        case (r_letter)
                            8'h56: begin
                                o_job.op <= OP_OK;
                                if (r_num_ok && r_num <= {1'b0, ABS_MAX}) r_max <= r_num[15:0];
                            end
                            8'h76: begin
                                o_job.op <= OP_OK;
                                if (r_num_ok && r_num <= {1'b0, r_max}) r_min <= r_num[15:0];
                            end
                            8'h63: begin
                                o_job.op <= OP_OK;
                                if (r_num_ok && r_num <= {1'b0, r_max}) r_cur <= r_num[15:0];
                            end
                            8'h64, 8'h73: o_job.op <= OP_OK;
                            8'h4D: o_job.op <= OP_DRIVE;
                            default: o_job.op <= OP_ZERO;
                        endcase
                    end
                end
            end else begin
                r_cnt <= 2'd2;
                r_exit <= (r_exit < 3'd4 && i_byte == exit_chr) ? r_exit + 3'd1 : 3'd7;
                if (is_digit) r_num <= (num_x10 > {4'd0, NUM_SAT}) ? NUM_SAT : num_x10[16:0];
                else r_num_ok <= 1'b0;
                if (!r_split && i_byte == 8'h2C) begin
                    r_split <= 1'b1;
                end else if (!r_split) begin
                    r_mph <= n_ph; r_mnz <= n_nz; r_mneg <= n_neg;
                end else begin
                    r_rph <= n_ph; r_rnz <= n_nz; r_rneg <= n_neg;
                end
            end
        end
    end
endmodule

@@ sv/mcp_queue.sv @@
// Small job queue between the parser and the reply generator.
`timescale 1ns / 1ps
module mcp_queue import mcp_pkg::*; #(
    parameter int DEPTH = QDEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    // Full leaves one spare slot for the job that is already in flight.
    assign o_full  = r_cnt >= (AW+1)'(DEPTH - 1);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

@@ sv/mcp_back.sv @@
// Back end: turns one job into reply characters or a motor update.
`timescale 1ns / 1ps
module mcp_back import mcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [71:0] o_tdata,
    output logic        o_tuser,
    output logic        o_tlast
);
    typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} t_state;
    t_state      r_state;
    logic [7:0]  r_buf [13];
    logic [3:0]  r_len, r_idx, r_k;
    logic [15:0] r_v;
    logic [16:0] q_mul;
    logic [15:0] q;
    logic [3:0]  rem;
    logic [15:0] cp, lf, lr, rf, rr;
    logic        emit_go, load_out;

    // Divide by ten via reciprocal: q = v*52429 >> 19 is exact below 65536.
    logic [32:0] prod;
    assign prod = 33'(r_v) * 33'd52429;
    assign q     = 16'(prod[32:19]);
    assign q_mul = 17'(q) * 17'd10;
    assign rem   = 4'(17'(r_v) - q_mul);

    assign cp = i_job.value;
    always_comb begin
        lf = 16'd0; lr = 16'd0; rf = 16'd0; rr = 16'd0;
        if (i_job.op == OP_BRAKE) begin
            lf = ABS_MAX; lr = ABS_MAX; rf = ABS_MAX; rr = ABS_MAX;
        end else if (!i_job.mv_nz && !i_job.rt_nz) begin
            lf = 16'd0;
        end else if (!i_job.rt_nz) begin
            if (i_job.mv_neg) begin lr = cp; rr = cp; end
            else begin lf = cp; rf = cp; end
        end else if (i_job.rt_neg) begin
            lr = cp; rf = cp;
        end else begin
            lf = cp; rr = cp;
        end
    end

    assign emit_go = !o_tvalid || i_tready;
    assign o_pop = r_state == S_IDLE && i_valid && emit_go;
    // The output register loads a new transfer on a motor job or a character.
    assign load_out = (o_pop && (i_job.op == OP_BRAKE || i_job.op == OP_DRIVE)) ||
                      (r_state == S_EMIT && emit_go);

    // Sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_tvalid <= 1'b0;
        end else begin
            if (load_out) o_tvalid <= 1'b1;
            else if (i_tready) o_tvalid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_pop) begin
                    case (i_job.op)
                        OP_BRAKE, OP_DRIVE: begin
                            o_tuser <= 1'b1; o_tlast <= 1'b1;
                            o_tdata <= {rr, rf, lr, lf, 8'd0};
                        end
                        OP_UNSUP: begin
                            r_buf[0] <= "u"; r_buf[1] <= "n"; r_buf[2] <= "s";
                            r_buf[3] <= "u"; r_buf[4] <= "p"; r_buf[5] <= "p";
                            r_buf[6] <= "o"; r_buf[7] <= "r"; r_buf[8] <= "t";
                            r_buf[9] <= "e"; r_buf[10] <= "d"; r_buf[11] <= 8'h0D;
                            r_buf[12] <= 8'h0A;
                            r_len <= 4'd13; r_idx <= 4'd0; r_state <= S_EMIT;
                        end
                        OP_OK: begin
                            r_buf[0] <= "O"; r_buf[1] <= "K"; r_buf[2] <= 8'h0D;
                            r_buf[3] <= 8'h0A; r_len <= 4'd4; r_idx <= 4'd0;
                            r_state <= S_EMIT;
                        end
                        OP_DEC: begin
                            r_v <= i_job.value; r_k <= 4'd4; r_state <= S_CONV;
                            r_buf[5] <= 8'h0D; r_buf[6] <= 8'h0A; r_len <= 4'd7;
                        end
                        default: begin
                            r_buf[0] <= "0"; r_buf[1] <= 8'h0D; r_buf[2] <= 8'h0A;
                            r_len <= 4'd3; r_idx <= 4'd0; r_state <= S_EMIT;
                        end
                    endcase
                end
                S_CONV: begin
                    // Digits fill right to left; start index follows the top digit.
                    r_buf[r_k] <= {4'h3, rem};
                    r_v <= q;
                    r_idx <= r_k;
                    if (q == 16'd0 || r_k == 4'd0) r_state <= S_EMIT;
                    else r_k <= r_k - 4'd1;
                end
                S_EMIT: if (emit_go) begin
                    o_tuser <= 1'b0;
                    o_tdata <= {64'd0, r_buf[r_idx]};
                    o_tlast <= r_idx == r_len - 4'd1;
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == r_len - 4'd1) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/motor_command_parser_top.sv @@
// Top level of the motor command parser.
`timescale 1ns / 1ps
// Motor command parser: takes one received ASCII byte per transfer on the
// s_axis channel and answers on the m_axis channel.
// m_axis tuser is the kind: 0 reply character, 1 motor level update.
// tdata carries reply_char, left_forward, left_reverse, right_forward,
// right_reverse from the lowest bit up; tlast marks the last result of a byte.
// Bytes are taken one per cycle while the job queue is not full; the
// parser state is registered. A terminating '#' queues a job, except
// after "exit", which halts the parser. The reply generator emits one
// result per cycle while the receiver is ready: a motor update directly,
// a text reply from a buffer, a decimal reply after digit conversion by
// divide by ten. The longest reply is 13 characters.
// The job queue holds a few commands; s_axis_tready falls when it is full.
// When the receiver stalls, the output register holds its transfer and the
// queue absorbs later commands. Reset clears parser state, power settings
// to their defaults and the queue; no clearing pass is needed.
module motor_command_parser_top import mcp_pkg::*; #(
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // reply_char, left_forward, left_reverse,
                                       // right_forward, right_reverse
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast   // last
);
`include "assert_macros.svh"
    logic job_v, full, q_valid, pop;
    t_job job, q_job;

    mcp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .i_byte(s_axis_tdata), .o_ready(s_axis_tready),
        .o_job_valid(job_v), .o_job(job), .i_job_full(full)
    );

    mcp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(job_v), .i_job(job),
        .o_full(full), .i_pop(pop), .o_valid(q_valid), .o_job(q_job)
    );

    mcp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_job(q_job),
        .o_pop(pop), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_tdata(m_axis_tdata), .o_tuser(m_axis_tuser), .o_tlast(m_axis_tlast)
    );

    `ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, pop, q_valid)
    `ASSERT_IMPLIES(a_motor_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata))
endmodule
